>>> rtl/hufd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hufd_pkg;

	// Default sizing, handed to the top level parameters
	localparam int NODE_COUNT_DEF   = 512;
	localparam int MAX_CODE_LEN_DEF = 16;

	// Fixed field widths
	localparam int CODE_W = 16;
	localparam int LEN_W  = 5;
	localparam int SYM_W  = 8;
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int BCNT_W = $clog2(BYTE_W + 1);

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic ins_chk;
		logic ins_out;
		logic dec_run;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic ins_fin;
		logic out_free;
		logic dec_done;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/hufd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hufd_ctrl import hufd_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  item_valid,
	input  wire  opcode,
	input  sts_t sts,
	output logic item_stall,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS,
		ST_INS_OUT,
		ST_DEC
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   accept;

	assign accept     = item_valid && !stall_q;
	assign item_stall = stall_q;

	// Commands decoded from the current state
	always_comb begin
		cmd          = '0;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.accept   = (state_q == ST_IDLE) && accept;
		cmd.ins_chk  = (state_q == ST_INS);
		cmd.ins_out  = (state_q == ST_INS_OUT);
		cmd.dec_run  = (state_q == ST_DEC);
	end

	// Sequencer; stall is high in every state but idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			stall_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= (opcode == OP_DECODE) ? ST_DEC : ST_INS;
						stall_q <= 1'b1;
					end
				end
				ST_INS: begin
					if (sts.ins_fin)
						state_q <= ST_INS_OUT;
				end
				ST_INS_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				ST_DEC: begin
					if (sts.dec_done) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					stall_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/hufd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module hufd_dpath import hufd_pkg::*; #(
	parameter int NODE_COUNT   = NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  wire               opcode,
	input  wire  [CODE_W-1:0] code_bits,
	input  wire  [LEN_W-1:0]  code_len,
	input  wire  [SYM_W-1:0]  symbol,
	input  wire  [BYTE_W-1:0] data_byte,
	input  wire               res_stall,
	output logic              res_valid,
	output logic [KIND_W-1:0] kind,
	output logic [SYM_W-1:0]  out_symbol,
	output logic              last
);

	localparam int IDX_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int FREE_W  = $clog2(NODE_COUNT + 1);
	localparam int WORD_W  = 2 * IDX_W + SYM_W;
	localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	// Node word: {left link, right link, symbol}; a zero link is no child
	function automatic logic [IDX_W-1:0] lft(input logic [WORD_W-1:0] w);
		return w[WORD_W-1 -: IDX_W];
	endfunction

	function automatic logic [IDX_W-1:0] rgt(input logic [WORD_W-1:0] w);
		return w[SYM_W +: IDX_W];
	endfunction

	function automatic logic [SYM_W-1:0] wsym(input logic [WORD_W-1:0] w);
		return w[SYM_W-1:0];
	endfunction

	function automatic logic is_leaf(input logic [WORD_W-1:0] w);
		return (w[WORD_W-1:SYM_W] == '0);
	endfunction

	// Node table
	logic [WORD_W-1:0] mem_q [NODE_COUNT];
	logic [WORD_W-1:0] rdata_q;
	logic              rd_en, wr_en;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	logic [WORD_W-1:0] wr_data;

	// Control state
	logic [FREE_W-1:0] free_q;
	logic [IDX_W-1:0]  node_q;
	logic [WORD_W-1:0] root_q;
	logic              fresh_q, arr_q;
	logic [IDX_W-1:0]  clr_q;
	logic              pend_v_q, out_v_q;

	// Item and walk payload
	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  rem_q;
	logic [SYM_W-1:0]  sym_q;
	logic [BYTE_W-1:0] byte_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic [IDX_W-1:0]  ins_node_q;
	logic [WORD_W-1:0] cur_q;
	logic [IDX_W-1:0]  arr_idx_q;
	logic [SYM_W-1:0]  pend_sym_q;
	logic [KIND_W-1:0] res_kind_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_last_q;

	// Length saturation and code alignment to the top bit
	logic [LEN_W-1:0] len_c;
	assign len_c = (code_len > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : code_len;

	// Insert step on the word just read
	logic             ins_bit, ins_has, ins_full, ins_end, ins_alloc;
	logic [IDX_W-1:0] ins_link, free_idx;

	assign ins_bit   = code_q[CODE_W-1];
	assign ins_link  = ins_bit ? rgt(rdata_q) : lft(rdata_q);
	assign ins_has   = (ins_link != '0);
	assign ins_full  = (free_q == FREE_W'(NODE_COUNT));
	assign ins_end   = (rem_q == '0);
	assign ins_alloc = !ins_end && !ins_has && !ins_full;
	assign free_idx  = free_q[IDX_W-1:0];

	// Decode: effective current node after any child read lands
	logic [IDX_W-1:0]  eff_idx;
	logic [WORD_W-1:0] eff_w;
	logic              arr_emit;

	always_comb begin
		eff_idx  = node_q;
		eff_w    = cur_q;
		arr_emit = 1'b0;
		if (fresh_q) begin
			eff_w = rdata_q;
		end else if (arr_q) begin
			if (is_leaf(rdata_q)) begin
				arr_emit = 1'b1;
				eff_idx  = '0;
				eff_w    = root_q;
			end else begin
				eff_idx = arr_idx_q;
				eff_w   = rdata_q;
			end
		end
	end

	logic             bit_act, take, miss_emit, emit, out_free, freeze, dec_end, dec_step;
	logic [IDX_W-1:0] child;
	logic [SYM_W-1:0] emit_sym;

	assign bit_act   = (bcnt_q != '0);
	assign child     = byte_q[BYTE_W-1] ? rgt(eff_w) : lft(eff_w);
	assign take      = bit_act && (child != '0);
	assign miss_emit = bit_act && (child == '0) && is_leaf(eff_w);
	assign emit      = arr_emit || miss_emit;
	assign emit_sym  = arr_emit ? wsym(rdata_q) : wsym(eff_w);
	assign out_free  = !out_v_q || !res_stall;
	assign freeze    = emit && pend_v_q && !out_free;
	assign dec_end   = !fresh_q && !arr_q && !bit_act;
	assign dec_step  = cmd.dec_run && !freeze && !dec_end;

	assign sts.clr_last = (clr_q == IDX_W'(NODE_COUNT - 1));
	assign sts.ins_fin  = ins_end || (!ins_has && ins_full);
	assign sts.out_free = out_free;
	assign sts.dec_done = dec_end && (!pend_v_q || out_free);

	// Table port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = node_q;
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end
		if (cmd.accept) begin
			rd_en   = 1'b1;
			rd_addr = (opcode == OP_DECODE) ? node_q : '0;
		end
		if (cmd.ins_chk) begin
			if (ins_end) begin
				wr_en   = 1'b1;
				wr_addr = ins_node_q;
				wr_data = {lft(rdata_q), rgt(rdata_q), sym_q};
			end else if (ins_has) begin
				rd_en   = 1'b1;
				rd_addr = ins_link;
			end else if (!ins_full) begin
				wr_en   = 1'b1;
				wr_addr = ins_node_q;
				wr_data = ins_bit ? {lft(rdata_q), free_idx, wsym(rdata_q)}
				                  : {free_idx, rgt(rdata_q), wsym(rdata_q)};
				rd_en   = 1'b1;
				rd_addr = free_idx;
			end
		end
		if (dec_step && take) begin
			rd_en   = 1'b1;
			rd_addr = child;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem_q[rd_addr];
	end

	// Output register load
	logic              out_load, out_last_d;
	logic [KIND_W-1:0] out_kind_d;
	logic [SYM_W-1:0]  out_sym_d;

	always_comb begin
		out_load   = 1'b0;
		out_kind_d = KIND_SYMBOL;
		out_sym_d  = pend_sym_q;
		out_last_d = 1'b0;
		if (cmd.ins_out && out_free) begin
			out_load   = 1'b1;
			out_kind_d = res_kind_q;
			out_sym_d  = '0;
			out_last_d = 1'b1;
		end else if (dec_step && emit && pend_v_q) begin
			out_load = 1'b1;
		end else if (cmd.dec_run && dec_end && pend_v_q && out_free) begin
			out_load   = 1'b1;
			out_last_d = 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= FREE_W'(1);
			node_q   <= '0;
			root_q   <= '0;
			fresh_q  <= 1'b0;
			arr_q    <= 1'b0;
			clr_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + IDX_W'(1);
			if (wr_en && (wr_addr == '0))
				root_q <= wr_data;
			if (cmd.ins_chk && ins_alloc)
				free_q <= free_q + FREE_W'(1);
			if (cmd.accept) begin
				fresh_q <= (opcode == OP_DECODE);
				arr_q   <= 1'b0;
			end
			if (dec_step) begin
				fresh_q <= 1'b0;
				arr_q   <= take;
				if (!take)
					node_q <= miss_emit ? '0 : eff_idx;
				if (emit)
					pend_v_q <= 1'b1;
			end
			if (cmd.dec_run && sts.dec_done)
				pend_v_q <= 1'b0;
			if (out_load)
				out_v_q <= 1'b1;
			else if (!res_stall)
				out_v_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			code_q     <= code_bits << (LEN_W'(CODE_W) - len_c);
			rem_q      <= len_c;
			sym_q      <= symbol;
			byte_q     <= data_byte;
			bcnt_q     <= BCNT_W'(BYTE_W);
			ins_node_q <= '0;
		end
		if (cmd.ins_chk) begin
			if (!ins_end && (ins_has || !ins_full)) begin
				ins_node_q <= ins_has ? ins_link : free_idx;
				rem_q      <= rem_q - LEN_W'(1);
				code_q     <= code_q << 1;
			end
			res_kind_q <= ins_end ? KIND_DONE : KIND_FULL;
		end
		if (dec_step) begin
			if (bit_act) begin
				bcnt_q <= bcnt_q - BCNT_W'(1);
				byte_q <= byte_q << 1;
			end
			if (take)
				arr_idx_q <= child;
			else
				cur_q <= miss_emit ? root_q : eff_w;
			if (emit)
				pend_sym_q <= emit_sym;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_sym_q  <= out_sym_d;
			out_last_q <= out_last_d;
		end
	end

	assign res_valid  = out_v_q;
	assign kind       = out_kind_q;
	assign out_symbol = out_sym_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire

>>> rtl/huffman_tree_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Huffman tree decoder with a node table of NODE_COUNT words.
// Input channel item_valid/item_stall carries one transaction per item:
// opcode 0 inserts a code (code_bits, code_len, symbol), opcode 1 decodes
// data_byte MSB first. Result channel res_valid/res_stall carries kind,
// out_symbol and last; last marks the final result of an item.
// One item is worked at a time; item_stall stays high until it is done.
// Decode: one node table read on the single read port for each bit that
// moves to a child; each symbol is held back until the next one is found
// or the byte ends, so that last can be set on the final one.
// Insert: one table read-modify-write per code bit after length saturation,
// stopping early when the table fills.
// Reset: a clearing pass writes every node word to zero, with item_stall
// held high; the tree is then empty.
// A stalled result holds the output register; the walk pauses only when a
// further symbol is found while one is already waiting behind it.
module huffman_tree_decoder import hufd_pkg::*; #(
	parameter int NODE_COUNT   = NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_stall,
	input  wire               opcode,
	input  wire  [CODE_W-1:0] code_bits,
	input  wire  [LEN_W-1:0]  code_len,
	input  wire  [SYM_W-1:0]  symbol,
	input  wire  [BYTE_W-1:0] data_byte,
	output logic              res_valid,
	input  wire               res_stall,
	output logic [KIND_W-1:0] kind,
	output logic [SYM_W-1:0]  out_symbol,
	output logic              last
);

	cmd_t cmd;
	sts_t sts;

	hufd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.opcode     (opcode),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	hufd_dpath #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.code_bits  (code_bits),
		.code_len   (code_len),
		.symbol     (symbol),
		.data_byte  (data_byte),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.kind       (kind),
		.out_symbol (out_symbol),
		.last       (last)
	);

	// Only one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second item accepted while one is in flight");

	// Insert results are single and carry no symbol
	a_ins_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind != KIND_SYMBOL) |-> last && (out_symbol == '0))
		else $error("insert result without last or with a symbol");

	// No commands to the datapath during the clearing pass but the sweep
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !cmd.accept && !cmd.ins_chk && !cmd.dec_run && !res_valid)
		else $error("activity during the clearing pass");

endmodule

`default_nettype wire

>>> sim/huffman_tree_decoder_check.sv
`timescale 1ns / 1ps

// Watches both channels of the tree decoder, keeps its own copy of the node
// table and walk position, and compares every result with the oldest one due.
module huffman_tree_decoder_check import hufd_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	input  wire               item_stall,
	input  wire               opcode,
	input  wire  [CODE_W-1:0] code_bits,
	input  wire  [LEN_W-1:0]  code_len,
	input  wire  [SYM_W-1:0]  symbol,
	input  wire  [BYTE_W-1:0] data_byte,
	input  wire               res_valid,
	input  wire               res_stall,
	input  wire  [KIND_W-1:0] kind,
	input  wire  [SYM_W-1:0]  out_symbol,
	input  wire               last,
	output int                fail_count,
	output int                pending,
	output int                symbol_count,
	output int                done_count,
	output int                full_count
);

	localparam int NODES    = NODE_COUNT_DEF;
	localparam int CODE_MAX = MAX_CODE_LEN_DEF;
	localparam int LINK_W   = $clog2(NODES) + 1;
	localparam int SHOW_MAX = 10;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  sym;
		logic              last;
	} outcome_t;

	// Mirror of the node table; a link of zero means no child
	logic [LINK_W-1:0] zero_kid [NODES];
	logic [LINK_W-1:0] one_kid  [NODES];
	logic [SYM_W-1:0]  node_sym [NODES];
	int                next_free;
	int                cursor;

	outcome_t outcomes_due[$];

	task automatic wipe_tree;
		for (int n = 0; n < NODES; n++) begin
			zero_kid[n] = '0;
			one_kid[n]  = '0;
			node_sym[n] = '0;
		end
		next_free = 1;
		cursor    = 0;
	endtask

	// Walk the code from its first bit, growing the tree; refuse when out of nodes
	function automatic logic [KIND_W-1:0] add_code(input logic [CODE_W-1:0] word,
			input logic [LEN_W-1:0] len_in, input logic [SYM_W-1:0] sym);
		int len;
		int node;
		int i;
		len  = len_in;
		node = 0;
		if (len > CODE_W)
			len = CODE_W;
		if (len > CODE_MAX)
			len = CODE_MAX;
		for (i = 0; i < len; i++) begin
			if (word[len - 1 - i]) begin
				if (one_kid[node] == 0) begin
					if (next_free >= NODES)
						return KIND_FULL;
					one_kid[node] = LINK_W'(next_free);
					next_free++;
				end
				node = one_kid[node];
			end else begin
				if (zero_kid[node] == 0) begin
					if (next_free >= NODES)
						return KIND_FULL;
					zero_kid[node] = LINK_W'(next_free);
					next_free++;
				end
				node = zero_kid[node];
			end
		end
		node_sym[node] = sym;
		return KIND_DONE;
	endfunction

	// Eight steps from the current node; a missing child leaves the bit unused
	task automatic walk_byte(input logic [BYTE_W-1:0] bits);
		int node;
		int b;
		int found;
		outcome_t tail;
		found = 0;
		for (b = BYTE_W - 1; b >= 0; b--) begin
			node = cursor;
			if (!bits[b] && zero_kid[node] != 0)
				node = zero_kid[node];
			else if (bits[b] && one_kid[node] != 0)
				node = one_kid[node];
			if (zero_kid[node] == 0 && one_kid[node] == 0) begin
				outcomes_due.push_back('{KIND_SYMBOL, node_sym[node], 1'b0});
				found++;
				node = 0;
			end
			cursor = node;
		end
		if (found > 0) begin
			tail = outcomes_due[outcomes_due.size() - 1];
			tail.last = 1'b1;
			outcomes_due[outcomes_due.size() - 1] = tail;
		end
	endtask

	// Compare one accepted result with the oldest outstanding one
	task automatic take_result;
		outcome_t due;
		if (outcomes_due.size() == 0) begin
			if (fail_count < SHOW_MAX)
				$display("%0t: unexpected result kind %0d symbol %02h last %0d",
					$realtime, kind, out_symbol, last);
			fail_count++;
		end else begin
			due = outcomes_due.pop_front();
			if (due.kind !== kind || due.sym !== out_symbol || due.last !== last) begin
				if (fail_count < SHOW_MAX)
					$display("%0t: kind/symbol/last expected %0d/%02h/%0d got %0d/%02h/%0d",
						$realtime, due.kind, due.sym, due.last, kind, out_symbol, last);
				fail_count++;
			end
			case (kind)
				KIND_SYMBOL: symbol_count++;
				KIND_DONE:   done_count++;
				KIND_FULL:   full_count++;
				default: ;
			endcase
		end
	endtask

	// Results first: nothing accepted on this edge can have produced one yet
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_tree();
			outcomes_due.delete();
			pending <= 0;
		end else begin
			if (res_valid && !res_stall)
				take_result();
			if (item_valid && !item_stall) begin
				if (opcode == OP_INSERT)
					outcomes_due.push_back('{add_code(code_bits, code_len, symbol), '0, 1'b1});
				else
					walk_byte(data_byte);
			end
			pending <= outcomes_due.size();
		end
	end

endmodule

>>> sim/huffman_tree_decoder_test.sv
`timescale 1ns / 1ps

module huffman_tree_decoder_test;
	import hufd_pkg::*;

	localparam int QUIET       = 40;
	localparam int DRAIN_LIMIT = 50000;
	localparam int RANDOM_ITEMS = 280;
	localparam int FILL_INSERTS = 60;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	logic              opcode;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_len;
	logic [SYM_W-1:0]  symbol;
	logic [BYTE_W-1:0] data_byte;
	logic              res_valid;
	logic              res_stall;
	logic [KIND_W-1:0] kind;
	logic [SYM_W-1:0]  out_symbol;
	logic              last;

	int fail_count;
	int pending;
	int symbol_count;
	int done_count;
	int full_count;

	int                burst_left;
	int                items_sent;
	int                pick;
	int                k;
	int                set_mask;
	logic [CODE_W-1:0] cw;
	logic [LEN_W-1:0]  cl;

	huffman_tree_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.code_bits  (code_bits),
		.code_len   (code_len),
		.symbol     (symbol),
		.data_byte  (data_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.kind       (kind),
		.out_symbol (out_symbol),
		.last       (last)
	);

	huffman_tree_decoder_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.code_bits    (code_bits),
		.code_len     (code_len),
		.symbol       (symbol),
		.data_byte    (data_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.out_symbol   (out_symbol),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending),
		.symbol_count (symbol_count),
		.done_count   (done_count),
		.full_count   (full_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side stalls in random modes, each held for a random stretch
	initial begin : stall_pattern
		int stretch;
		int mode;
		stretch   = 0;
		mode      = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (stretch == 0) begin
				stretch = $urandom_range(20, 90);
				mode    = $urandom_range(0, 3);
			end
			stretch--;
			case (mode)
				0:       res_stall <= 1'b0;
				1:       res_stall <= ($urandom_range(0, 1) == 0);
				2:       res_stall <= ($urandom_range(0, 9) != 0);
				default: res_stall <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// Offer one transaction; the sender may pause between bursts of random length
	task automatic offer_item(input logic op, input logic [CODE_W-1:0] cwd,
			input logic [LEN_W-1:0] cln, input logic [SYM_W-1:0] sy,
			input logic [BYTE_W-1:0] db);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				item_valid <= 1'b0;
				opcode     <= 1'($urandom);
				data_byte  <= BYTE_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		opcode     <= op;
		code_bits  <= cwd;
		code_len   <= cln;
		symbol     <= sy;
		data_byte  <= db;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic insert_code(input logic [CODE_W-1:0] cwd, input logic [LEN_W-1:0] cln,
			input logic [SYM_W-1:0] sy);
		offer_item(OP_INSERT, cwd, cln, sy, BYTE_W'($urandom));
	endtask

	// Unused insert fields carry noise on decodes
	task automatic decode_byte(input logic [BYTE_W-1:0] db);
		offer_item(OP_DECODE, CODE_W'($urandom), LEN_W'($urandom), SYM_W'($urandom), db);
	endtask

	// Hold off until every outstanding result is in, then let the walk settle
	task automatic drain_results;
		int waited;
		waited = 0;
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (QUIET) @(posedge clk);
		burst_left = 0;
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		opcode     = OP_INSERT;
		code_bits  = '0;
		code_len   = '0;
		symbol     = '0;
		data_byte  = '0;
		burst_left = 0;
		items_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Empty tree, empty code at the root, long codes, no-leaf walks, re-inserts
		decode_byte(8'h00);
		insert_code(16'hFFFF, 5'd0, 8'hA5);
		decode_byte(8'hFF);
		insert_code(16'hFFFF, 5'd31, 8'hFF);
		insert_code(16'h0000, 5'd1, 8'h11);
		decode_byte(8'hFF);
		decode_byte(8'hFF);
		decode_byte(8'h00);
		insert_code(16'h0002, 5'd2, 8'h22);
		insert_code(16'h0000, 5'd1, 8'h33);
		insert_code(16'h0001, 5'd2, 8'h44);
		insert_code(16'h0000, 5'd2, 8'h55);
		decode_byte(8'h96);
		insert_code(16'h1234, 5'd17, 8'h66);
		insert_code(16'hAAAA, 5'd16, 8'h77);
		insert_code(16'h5555, 5'd16, 8'h00);
		decode_byte(8'hAA);
		decode_byte(8'h55);
		decode_byte(8'h0F);
		decode_byte(8'hF0);
		decode_byte(8'h69);
		drain_results();

		// Mostly decodes over a growing tree, with whole code sets now and then
		repeat (RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				k        = $urandom_range(1, 4);
				set_mask = $urandom_range(0, (1 << k) - 1);
				for (int c = 0; c < (1 << k); c++) begin
					cw = CODE_W'($urandom);
					cw = (cw & ~CODE_W'((1 << k) - 1)) | CODE_W'(c ^ set_mask);
					insert_code(cw, LEN_W'(k), SYM_W'($urandom));
				end
			end else if (pick < 30) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					cl = LEN_W'($urandom_range(1, 5));
				else if (pick < 85)
					cl = LEN_W'($urandom_range(6, 10));
				else if (pick < 92)
					cl = '0;
				else
					cl = LEN_W'($urandom_range(11, 31));
				insert_code(CODE_W'($urandom), cl, SYM_W'($urandom));
			end else begin
				decode_byte(BYTE_W'($urandom));
			end
		end
		drain_results();

		// Deep codes until the node table runs out, decoding in between
		for (int n = 0; n < FILL_INSERTS; n++) begin
			insert_code(CODE_W'($urandom), 5'd16, SYM_W'($urandom));
			if (n % 3 == 0)
				decode_byte(BYTE_W'($urandom));
		end
		repeat (10) decode_byte(BYTE_W'($urandom));
		drain_results();

		$display("%0d transactions sent: %0d symbols decoded, %0d codes stored,",
			items_sent, symbol_count, done_count);
		$display("%0d codes refused with the node table full", full_count);
		if (fail_count == 0 && pending == 0) begin
			$display("huffman_tree_decoder_test passed");
		end else begin
			if (pending != 0)
				$display("%0d expected results never arrived", pending);
			$display("huffman_tree_decoder_test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("huffman_tree_decoder_test failed");
		$finish;
	end

endmodule
